@@ hw/rtl/ltpd_pkg.sv @@
// ltpd_pkg: shared types, constants, microcode table and helper functions
// for the line tracking pid drive block. Used by every module in hw/rtl.
// No dependencies.
package ltpd_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_SPEED  = 3'd0,
        REG_PROP_GAIN   = 3'd1,
        REG_INTEG_GAIN  = 3'd2,
        REG_DERIV_GAIN  = 3'd3,
        REG_RIGHT_TRIM  = 3'd4
    } reg_idx_t;

    // register widths and reset values
    localparam int BASE_W  = 14;
    localparam int KP_W    = 18;
    localparam int KI_W    = 16;
    localparam int KD_W    = 16;
    localparam int TRIM_W  = 9;

    localparam logic [BASE_W-1:0] BASE_RST = 14'd2000;
    localparam logic [KP_W-1:0]   KP_RST   = 18'd153600;
    localparam logic [KI_W-1:0]   KI_RST   = 16'd26;
    localparam logic [KD_W-1:0]   KD_RST   = 16'd1280;
    localparam logic [TRIM_W-1:0] TRIM_RST = 9'd274;

    // datapath widths
    localparam int ERR_W  = 3;
    localparam int SUM_W  = 16;
    localparam int OPA_W  = 27;
    localparam int OPB_W  = 19;
    localparam int ACC_W  = OPA_W + OPB_W;
    localparam int CORR_W = 25;
    localparam int RQ_W   = 28;
    localparam int SPD_W  = 15;
    localparam int DUTY_W = 14;

    localparam logic signed [RQ_W-1:0] SPEED_MAX = 28'sd9999;
    localparam logic signed [RQ_W-1:0] SPEED_MIN = -28'sd4999;

    // microcode fields
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [1:0] {
        COND_NONE,   // fall through to the next step
        COND_IN,     // hold until an input item is taken
        COND_OUT     // hold until the output slot is free, then jump
    } cond_t;

    typedef enum logic [1:0] {
        MUL_KP_E,
        MUL_KI_SUM,
        MUL_KD_D,
        MUL_TRIM_DIFF
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        cond_t    cond;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     corr_en;   // split acc into correction, form left speed
        logic     last_en;   // remember this tick's error
        logic     out_en;    // result goes to the output register
        step_t    target;
    } uword_t;

    // microprogram: one control word per step
    function automatic uword_t ucode(input step_t step);
        uword_t w;
        w = '{cond: COND_NONE, mul_sel: MUL_KP_E, acc_op: ACC_HOLD,
              corr_en: 1'b0, last_en: 1'b0, out_en: 1'b0, target: '0};
        unique case (step)
            3'd0: w.cond = COND_IN;
            3'd1: w.acc_op = ACC_LOAD;
            3'd2:
            begin
                w.mul_sel = MUL_KI_SUM;
                w.acc_op  = ACC_ADD;
            end
            3'd3:
            begin
                w.mul_sel = MUL_KD_D;
                w.acc_op  = ACC_ADD;
                w.last_en = 1'b1;
            end
            3'd4: w.corr_en = 1'b1;
            3'd5:
            begin
                w.mul_sel = MUL_TRIM_DIFF;
                w.acc_op  = ACC_LOAD;
            end
            3'd6:
            begin
                w.cond   = COND_OUT;
                w.out_en = 1'b1;
                w.target = 3'd0;
            end
            default: w.cond = COND_NONE;
        endcase
        return w;
    endfunction

    // sensor pattern decode
    typedef struct packed {
        logic                    hit;
        logic signed [ERR_W-1:0] err;
    } decode_t;

    function automatic decode_t decode_line(input logic [3:0] pat);
        decode_t d;
        d.hit = 1'b1;
        d.err = 3'sd0;
        unique case (pat)
            4'b1000: d.err = -3'sd3;
            4'b1100: d.err = -3'sd2;
            4'b0100: d.err = -3'sd1;
            4'b0110: d.err = 3'sd0;
            4'b0010: d.err = 3'sd1;
            4'b0011: d.err = 3'sd2;
            4'b0001: d.err = 3'sd3;
            4'b0000: d.err = 3'sd0;
            default: d.hit = 1'b0;
        endcase
        return d;
    endfunction

    // 16-bit saturating sum of the integral and a small error
    function automatic logic signed [SUM_W-1:0] sat_sum(
        input logic signed [SUM_W-1:0] sum,
        input logic signed [ERR_W-1:0] err
    );
        logic signed [SUM_W:0] s;
        s = {sum[SUM_W-1], sum} + {{(SUM_W-ERR_W+1){err[ERR_W-1]}}, err};
        if (s[SUM_W] != s[SUM_W-1])
        begin
            return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return s[SUM_W-1:0];
    endfunction

    // clamp a speed to the drive range
    function automatic logic signed [SPD_W-1:0] clamp_speed(
        input logic signed [RQ_W-1:0] v
    );
        priority if (v > SPEED_MAX)
            return SPEED_MAX[SPD_W-1:0];
        else if (v < SPEED_MIN)
            return SPEED_MIN[SPD_W-1:0];
        else
            return v[SPD_W-1:0];
    endfunction

    // signed divide by 256, rounding toward zero
    function automatic logic signed [ACC_W-1:0] div256(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] adj;
        adj = x + $signed({{(ACC_W-8){1'b0}}, {8{x[ACC_W-1]}}});
        return adj >>> 8;
    endfunction

endpackage

@@ hw/rtl/ltpd_seq.sv @@
// ltpd_seq: step counter and microcode table for the pid drive.
// Depends on ltpd_pkg.
module ltpd_seq
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_accept,
    input  logic              out_free,
    output ltpd_pkg::uword_t  uword
);

    ltpd_pkg::step_t step_reg;
    ltpd_pkg::step_t step_next;

    // control word of the current step
    assign uword = ltpd_pkg::ucode(step_reg);

    // next step: fall through, wait on a condition, or jump
    always_comb
    begin
        step_next = step_reg;
        unique case (uword.cond)
            ltpd_pkg::COND_NONE: step_next = step_reg + 1'b1;
            ltpd_pkg::COND_IN:
            begin
                if (in_accept)
                    step_next = step_reg + 1'b1;
            end
            ltpd_pkg::COND_OUT:
            begin
                if (out_free)
                    step_next = uword.target;
            end
            default: step_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else
            step_reg <= step_next;
    end

endmodule

@@ hw/rtl/ltpd_datapath.sv @@
// ltpd_datapath: error decode, integral, shared multiplier with accumulator,
// speed clamp and result registers. Driven by control words from ltpd_seq.
// Depends on ltpd_pkg.
module ltpd_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ltpd_pkg::uword_t                     uword,
    input  logic                                 in_accept,
    input  logic                                 out_load,
    input  logic [3:0]                           pattern,
    input  logic [ltpd_pkg::BASE_W-1:0]          base_speed,
    input  logic [ltpd_pkg::KP_W-1:0]            prop_gain_q8,
    input  logic [ltpd_pkg::KI_W-1:0]            integ_gain_q8,
    input  logic [ltpd_pkg::KD_W-1:0]            deriv_gain_q8,
    input  logic [ltpd_pkg::TRIM_W-1:0]          right_trim_q8,
    output logic                                 left_forward,
    output logic [ltpd_pkg::DUTY_W-1:0]          left_duty,
    output logic                                 right_forward,
    output logic [ltpd_pkg::DUTY_W-1:0]          right_duty,
    output logic signed [ltpd_pkg::ERR_W-1:0]    line_error
);

    localparam int ERR_W  = ltpd_pkg::ERR_W;
    localparam int SUM_W  = ltpd_pkg::SUM_W;
    localparam int OPA_W  = ltpd_pkg::OPA_W;
    localparam int OPB_W  = ltpd_pkg::OPB_W;
    localparam int ACC_W  = ltpd_pkg::ACC_W;
    localparam int CORR_W = ltpd_pkg::CORR_W;
    localparam int RQ_W   = ltpd_pkg::RQ_W;
    localparam int SPD_W  = ltpd_pkg::SPD_W;
    localparam int DUTY_W = ltpd_pkg::DUTY_W;
    localparam int BASE_W = ltpd_pkg::BASE_W;

    // pid state
    logic signed [ERR_W-1:0]  held_reg, held_next;
    logic signed [ERR_W-1:0]  last_reg;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [OPA_W-1:0]  diff_reg;
    logic signed [SPD_W-1:0]  left_reg;

    ltpd_pkg::decode_t        dec;
    logic signed [ERR_W:0]    d_err;
    logic signed [OPA_W-1:0]  op_a;
    logic signed [OPB_W-1:0]  op_b;
    logic signed [ACC_W-1:0]  prod;
    logic signed [ACC_W-1:0]  quot;
    logic signed [CORR_W-1:0] corr;
    logic signed [RQ_W-1:0]   base_ext;
    logic signed [RQ_W-1:0]   left_sum;
    logic signed [SPD_W-1:0]  right_spd;

    // line decode and integral update for a new item
    always_comb
    begin
        dec       = ltpd_pkg::decode_line(pattern);
        held_next = dec.hit ? dec.err : held_reg;
        if (held_next > -3'sd2 && held_next < 3'sd2)
            sum_next = ltpd_pkg::sat_sum(sum_reg, held_next);
        else
            sum_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            last_reg <= '0;
            sum_reg  <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                held_reg <= held_next;
                sum_reg  <= sum_next;
            end
            if (uword.last_en)
                last_reg <= held_reg;
        end
    end

    // operand select for the shared multiplier
    assign d_err = {held_reg[ERR_W-1], held_reg} - {last_reg[ERR_W-1], last_reg};

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (uword.mul_sel)
            ltpd_pkg::MUL_KP_E:
            begin
                op_a = {{(OPA_W-ERR_W){held_reg[ERR_W-1]}}, held_reg};
                op_b = $signed({{(OPB_W-ltpd_pkg::KP_W){1'b0}}, prop_gain_q8});
            end
            ltpd_pkg::MUL_KI_SUM:
            begin
                op_a = {{(OPA_W-SUM_W){sum_reg[SUM_W-1]}}, sum_reg};
                op_b = $signed({{(OPB_W-ltpd_pkg::KI_W){1'b0}}, integ_gain_q8});
            end
            ltpd_pkg::MUL_KD_D:
            begin
                op_a = {{(OPA_W-ERR_W-1){d_err[ERR_W]}}, d_err};
                op_b = $signed({{(OPB_W-ltpd_pkg::KD_W){1'b0}}, deriv_gain_q8});
            end
            ltpd_pkg::MUL_TRIM_DIFF:
            begin
                op_a = diff_reg;
                op_b = $signed({{(OPB_W-ltpd_pkg::TRIM_W){1'b0}}, right_trim_q8});
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod = op_a * op_b;

    // accumulator
    always_ff @(posedge clk)
    begin
        unique case (uword.acc_op)
            ltpd_pkg::ACC_LOAD: acc_reg <= prod;
            ltpd_pkg::ACC_ADD:  acc_reg <= acc_reg + prod;
            ltpd_pkg::ACC_HOLD: acc_reg <= acc_reg;
            default:            acc_reg <= acc_reg;
        endcase
    end

    // correction, left speed and right pre-trim difference
    assign quot     = ltpd_pkg::div256(acc_reg);
    assign corr     = quot[CORR_W-1:0];
    assign base_ext = $signed({{(RQ_W-BASE_W){1'b0}}, base_speed});
    assign left_sum = base_ext + {{(RQ_W-CORR_W){corr[CORR_W-1]}}, corr};

    always_ff @(posedge clk)
    begin
        if (uword.corr_en)
        begin
            left_reg <= ltpd_pkg::clamp_speed(left_sum);
            diff_reg <= base_ext[OPA_W-1:0] - {{(OPA_W-CORR_W){corr[CORR_W-1]}}, corr};
        end
    end

    // right speed from the trimmed product
    assign right_spd = ltpd_pkg::clamp_speed(quot[RQ_W-1:0]);

    // result registers
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            left_forward  <= !left_reg[SPD_W-1] && (left_reg != '0);
            left_duty     <= left_reg[SPD_W-1] ? DUTY_W'(-left_reg) : left_reg[DUTY_W-1:0];
            right_forward <= !right_spd[SPD_W-1] && (right_spd != '0);
            right_duty    <= right_spd[SPD_W-1] ? DUTY_W'(-right_spd)
                                                : right_spd[DUTY_W-1:0];
            line_error    <= held_reg;
        end
    end

endmodule

@@ hw/rtl/line_track_pid_drive.sv @@
// line_track_pid_drive: top level of the line following pid drive.
// Holds configuration registers and handshakes; instantiates ltpd_seq and
// ltpd_datapath. Depends on ltpd_pkg.
//
// Each input item is one control tick of four line-sensor bits; it yields one
// result item with a direction bit and a duty for each wheel plus the line
// error used. The microprogram runs one step per cycle, except while it waits
// for an item or a free output slot, through a single shared multiplier: after
// acceptance it forms the three pid products, then the correction and left
// speed, then the trim product, and then writes the result. A new item is taken
// only in the first step, so the block cannot take a new item until it has gone
// through the last step for the previous one; a stalled result holds the
// sequencer at its last step. The result register lets the next item be
// accepted while the previous result still waits. Configuration writes are
// taken in any cycle and should only be made while the block is idle.
module line_track_pid_drive
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_we,
    input  logic [ltpd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ltpd_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 outer_left,
    input  logic                                 inner_left,
    input  logic                                 inner_right,
    input  logic                                 outer_right,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 left_forward,
    output logic [ltpd_pkg::DUTY_W-1:0]          left_duty,
    output logic                                 right_forward,
    output logic [ltpd_pkg::DUTY_W-1:0]          right_duty,
    output logic signed [ltpd_pkg::ERR_W-1:0]    line_error
);

    logic [ltpd_pkg::BASE_W-1:0] base_reg;
    logic [ltpd_pkg::KP_W-1:0]   kp_reg;
    logic [ltpd_pkg::KI_W-1:0]   ki_reg;
    logic [ltpd_pkg::KD_W-1:0]   kd_reg;
    logic [ltpd_pkg::TRIM_W-1:0] trim_reg;

    ltpd_pkg::uword_t uword;
    logic             in_accept;
    logic             out_free;
    logic             out_load;
    logic             out_valid_reg, out_valid_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= ltpd_pkg::BASE_RST;
            kp_reg   <= ltpd_pkg::KP_RST;
            ki_reg   <= ltpd_pkg::KI_RST;
            kd_reg   <= ltpd_pkg::KD_RST;
            trim_reg <= ltpd_pkg::TRIM_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ltpd_pkg::REG_BASE_SPEED: base_reg <= cfg_data[ltpd_pkg::BASE_W-1:0];
                ltpd_pkg::REG_PROP_GAIN:  kp_reg   <= cfg_data[ltpd_pkg::KP_W-1:0];
                ltpd_pkg::REG_INTEG_GAIN: ki_reg   <= cfg_data[ltpd_pkg::KI_W-1:0];
                ltpd_pkg::REG_DERIV_GAIN: kd_reg   <= cfg_data[ltpd_pkg::KD_W-1:0];
                ltpd_pkg::REG_RIGHT_TRIM: trim_reg <= cfg_data[ltpd_pkg::TRIM_W-1:0];
                default:                  base_reg <= base_reg;
            endcase
        end
    end

    // handshakes
    assign in_stall  = (uword.cond != ltpd_pkg::COND_IN);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = uword.out_en && out_free;
    assign out_valid = out_valid_reg;

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    ltpd_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .out_free  (out_free),
        .uword     (uword)
    );

    ltpd_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .uword         (uword),
        .in_accept     (in_accept),
        .out_load      (out_load),
        .pattern       ({outer_left, inner_left, inner_right, outer_right}),
        .base_speed    (base_reg),
        .prop_gain_q8  (kp_reg),
        .integ_gain_q8 (ki_reg),
        .deriv_gain_q8 (kd_reg),
        .right_trim_q8 (trim_reg),
        .left_forward  (left_forward),
        .left_duty     (left_duty),
        .right_forward (right_forward),
        .right_duty    (right_duty),
        .line_error    (line_error)
    );

endmodule
